FILE: rtl/lsct_pkg.sv
package lsct_pkg;

	// Command codes of an input item.
	typedef enum logic [1:0] {
		CMD_START  = 2'd0,
		CMD_CAL    = 2'd1,
		CMD_FINISH = 2'd2,
		CMD_RUN    = 2'd3
	} lsct_cmd_t;

	// Status codes of a result item.
	typedef enum logic [1:0] {
		STAT_OK         = 2'd0,
		STAT_REFUSED    = 2'd1,
		STAT_NOT_IN_USE = 2'd2,
		STAT_UNUSED     = 2'd3
	} lsct_status_t;

	// Configuration register indexes.
	localparam logic [1:0] CFG_SENSOR_COUNT = 2'd0;
	localparam logic [1:0] CFG_TOLERANCE    = 2'd1;

	// Fixed field widths.
	localparam int CH_W    = 3;
	localparam int RD_W    = 10;
	localparam int MASK_W  = 8;
	localparam int COUNT_W = 4;
	localparam int TOL_W   = 9;
	localparam int CFG_W   = 9;

	// Unity in Q1.8.
	localparam logic [TOL_W-1:0] ONE_Q8 = 9'd256;

	// An item after classification by the front end.
	typedef struct packed {
		lsct_cmd_t         cmd;
		logic [CH_W-1:0]   ch;
		logic [RD_W-1:0]   rd;
		logic              ch_ok;
		logic              in_use;
		logic              start_ok;
	} lsct_item_t;

	// Head of the queue as seen by the back end.
	typedef struct packed {
		logic       valid;
		lsct_item_t item;
	} lsct_head_t;

	// Back end status toward the queue and the top level.
	typedef struct packed {
		logic pop;
		logic busy;
	} lsct_back_stat_t;

endpackage

FILE: rtl/line_sensor_calibrate_threshold.sv
// Start, calibration and run items pass through the two-item input queue and the result register.
// A finish item during calibration gives its result after the back end has walked the channels,
// one channel per cycle through its single threshold multiply unit.
// Throughput: one item per cycle for start, calibration and run while out_stall is low; a finish
// during calibration holds the back end for its walk while a two-item queue takes input until full.
// Reset (arst_n, asynchronous): tables read as their reset values at once, no clearing pass.
module line_sensor_calibrate_threshold import lsct_pkg::*; #(
	parameter int CHANNELS    = 8,
	parameter int SAMPLE_BITS = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          cmd,
	input  logic [CH_W-1:0]     channel,
	input  logic [RD_W-1:0]     reading,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          status,
	output logic                on_line,
	output logic [MASK_W-1:0]   line_mask,
	output logic [MASK_W-1:0]   prev_mask,
	output logic [RD_W-1:0]     threshold
);

	logic [COUNT_W-1:0] sensor_count_q;
	logic [TOL_W-1:0]   tolerance_q;
	lsct_head_t         head;
	lsct_back_stat_t    back_stat;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_count_q <= '0;
			tolerance_q    <= 9'd128;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_SENSOR_COUNT) begin
				sensor_count_q <= cfg_data[COUNT_W-1:0];
			end else if (cfg_index == CFG_TOLERANCE) begin
				tolerance_q <= cfg_data[TOL_W-1:0];
			end
		end
	end

	lsct_front #(
		.CHANNELS (CHANNELS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.channel      (channel),
		.reading      (reading),
		.sensor_count (sensor_count_q),
		.pop          (back_stat.pop),
		.head         (head)
	);

	lsct_back #(
		.CHANNELS    (CHANNELS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.tolerance (tolerance_q),
		.stat      (back_stat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.on_line   (on_line),
		.line_mask (line_mask),
		.prev_mask (prev_mask),
		.threshold (threshold)
	);

	// The back end only takes an item that the queue holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.pop |-> head.valid)
		else $error("queue popped while empty");

	// No item is taken while the finish walk runs.
	assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.busy |-> !back_stat.pop)
		else $error("item taken during threshold walk");

	// A new result follows either a taken item or the end of a walk.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(back_stat.pop) || $past(back_stat.busy)))
		else $error("result produced without a source item");

endmodule

FILE: rtl/lsct_front.sv
module lsct_front import lsct_pkg::*; #(
	parameter int CHANNELS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          cmd,
	input  logic [CH_W-1:0]     channel,
	input  logic [RD_W-1:0]     reading,
	input  logic [COUNT_W-1:0]  sensor_count,
	input  logic                pop,
	output lsct_head_t          head
);

	lsct_item_t item_in;
	lsct_item_t q_mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;

	// Classify the incoming item against the channel configuration.
	always_comb begin
		item_in.cmd      = lsct_cmd_t'(cmd);
		item_in.ch       = channel;
		item_in.rd       = reading;
		item_in.ch_ok    = 5'(channel) < 5'(CHANNELS);
		item_in.in_use   = item_in.ch_ok && (5'(channel) < 5'(sensor_count));
		item_in.start_ok = 5'(sensor_count) == 5'(CHANNELS);
	end

	assign in_stall   = count_q == 2'd2;
	assign push       = in_valid && !in_stall;
	assign head.valid = count_q != 2'd0;
	assign head.item  = q_mem_q[rd_ptr_q];

	// Two-entry queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= item_in;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

FILE: rtl/lsct_back.sv
module lsct_back import lsct_pkg::*; #(
	parameter int CHANNELS    = 8,
	parameter int SAMPLE_BITS = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lsct_head_t          head,
	input  logic [TOL_W-1:0]    tolerance,
	output lsct_back_stat_t     stat,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          status,
	output logic                on_line,
	output logic [MASK_W-1:0]   line_mask,
	output logic [MASK_W-1:0]   prev_mask,
	output logic [RD_W-1:0]     threshold
);

	localparam int SB   = SAMPLE_BITS;
	localparam int IDXW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int RDU  = (SAMPLE_BITS < RD_W) ? SAMPLE_BITS : RD_W;
	localparam logic [SB-1:0] SAMPLE_MAX = {SB{1'b1}};

	typedef enum logic [1:0] {
		ST_EXEC,
		ST_WALK,
		ST_DONE
	} state_t;

	state_t state_q;

	// Calibration and threshold tables, one entry per channel.
	logic [SB-1:0]       low_q  [CHANNELS];
	logic [SB-1:0]       high_q [CHANNELS];
	logic [SB-1:0]       thr_q  [CHANNELS];
	logic [CHANNELS-1:0] cal_vld_q;
	logic                cal_q;
	logic [CHANNELS-1:0] mask_q;
	logic [CHANNELS-1:0] before_q;
	logic [IDXW-1:0]     idx_q;
	logic [CH_W-1:0]     ch_q;
	logic                ch_ok_q;

	logic                out_valid_q;
	lsct_status_t        status_q;
	logic                on_line_q;
	logic [MASK_W-1:0]   line_mask_q;
	logic [MASK_W-1:0]   prev_mask_q;
	logic [RD_W-1:0]     threshold_q;

	lsct_item_t          it;
	logic [IDXW-1:0]     ch_idx;
	logic [IDXW-1:0]     tab_addr;
	logic [IDXW-1:0]     thr_addr;
	logic [SB-1:0]       rd_s;
	logic [SB-1:0]       low_eff;
	logic [SB-1:0]       high_eff;
	logic [TOL_W-1:0]    tol_sat;
	logic signed [SB:0]  diff;
	logic signed [SB+10:0] prod;
	logic signed [SB+10:0] total;
	logic [SB-1:0]       thr_new;
	logic [SB-1:0]       thr_rd;
	logic [RD_W-1:0]     thr_out;
	logic                out_free;
	logic                out_load;
	logic                fin_go;
	logic                pop;
	logic                cal_upd;
	logic                cal_low;
	logic                run_upd;
	logic                hit;
	logic [CHANNELS-1:0] mask_nxt;
	logic [CHANNELS-1:0] before_nxt;
	lsct_status_t        status_nxt;

	assign it       = head.item;
	assign ch_idx   = IDXW'(it.ch);
	assign rd_s     = SB'(it.rd[RDU-1:0]);
	assign out_free = !out_valid_q || !out_stall;

	// One shared read port per table: walk index or item channel, for thresholds finish or item channel.
	assign tab_addr = (state_q == ST_WALK) ? idx_q : ch_idx;
	assign thr_addr = (state_q == ST_DONE) ? IDXW'(ch_q) : ch_idx;
	assign low_eff  = cal_vld_q[tab_addr] ? low_q[tab_addr] : SAMPLE_MAX;
	assign high_eff = cal_vld_q[tab_addr] ? high_q[tab_addr] : '0;
	assign thr_rd   = thr_q[thr_addr];

	// Threshold unit: low + (high - low) * tolerance, truncated to whole samples.
	always_comb begin
		tol_sat = (tolerance > ONE_Q8) ? ONE_Q8 : tolerance;
		diff    = $signed({1'b0, high_eff}) - $signed({1'b0, low_eff});
		prod    = diff * $signed({1'b0, tol_sat});
		total   = prod + $signed({3'b000, low_eff, 8'h00});
		thr_new = total[SB+10] ? '0 : total[SB+7:8];
	end

	// Decode the head item.
	always_comb begin
		fin_go     = head.valid && (it.cmd == CMD_FINISH) && cal_q;
		pop        = (state_q == ST_EXEC) && head.valid && (fin_go || out_free);
		cal_upd    = (it.cmd == CMD_CAL) && cal_q && it.in_use;
		cal_low    = rd_s < low_eff;
		run_upd    = (it.cmd == CMD_RUN) && it.in_use;
		hit        = run_upd && (rd_s > thr_rd);
		mask_nxt   = mask_q;
		before_nxt = before_q;
		if (run_upd) begin
			if (it.ch == '0) begin
				before_nxt = mask_q;
			end
			mask_nxt[ch_idx] = hit;
		end
		unique case (it.cmd)
			CMD_START:  status_nxt = it.start_ok ? STAT_OK : STAT_REFUSED;
			CMD_CAL:    status_nxt = !cal_q ? STAT_REFUSED :
			                         (it.in_use ? STAT_OK : STAT_NOT_IN_USE);
			CMD_FINISH: status_nxt = cal_q ? STAT_OK : STAT_REFUSED;
			CMD_RUN:    status_nxt = it.in_use ? STAT_OK : STAT_NOT_IN_USE;
			default:    status_nxt = STAT_REFUSED;
		endcase
	end

	assign thr_out = ((state_q == ST_DONE) ? ch_ok_q : it.ch_ok) ? RD_W'(thr_rd) : '0;

	// A result is loaded for every item except a finish that starts the walk,
	// and once more when the walk has ended.
	assign out_load = (pop && !fin_go) || ((state_q == ST_DONE) && out_free);

	assign stat.pop  = pop;
	assign stat.busy = state_q != ST_EXEC;

	// Table payload writes.
	always_ff @(posedge clk) begin
		if (pop && cal_upd) begin
			if (cal_low) begin
				low_q[ch_idx]  <= rd_s;
				high_q[ch_idx] <= high_eff;
			end else begin
				low_q[ch_idx]  <= low_eff;
				high_q[ch_idx] <= (rd_s > high_eff) ? rd_s : high_eff;
			end
		end
	end

	// Threshold table, cleared at reset and rewritten by the finish walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				thr_q[i] <= '0;
			end
		end else if (state_q == ST_WALK) begin
			thr_q[idx_q] <= thr_new;
		end
	end

	// Sequencer, calibration state, masks and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_EXEC;
			cal_vld_q   <= '0;
			cal_q       <= 1'b0;
			mask_q      <= '0;
			before_q    <= '0;
			idx_q       <= '0;
			ch_q        <= '0;
			ch_ok_q     <= 1'b0;
			out_valid_q <= 1'b0;
			status_q    <= STAT_OK;
			on_line_q   <= 1'b0;
			line_mask_q <= '0;
			prev_mask_q <= '0;
			threshold_q <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_EXEC: begin
					if (pop && fin_go) begin
						state_q <= ST_WALK;
						idx_q   <= '0;
						ch_q    <= it.ch;
						ch_ok_q <= it.ch_ok;
					end else if (pop) begin
						if (it.cmd == CMD_START && it.start_ok) begin
							cal_vld_q <= '0;
							cal_q     <= 1'b1;
						end
						if (cal_upd) begin
							cal_vld_q[ch_idx] <= 1'b1;
						end
						mask_q      <= mask_nxt;
						before_q    <= before_nxt;
						status_q    <= status_nxt;
						on_line_q   <= hit;
						line_mask_q <= MASK_W'(mask_nxt);
						prev_mask_q <= MASK_W'(before_nxt);
						threshold_q <= thr_out;
					end
				end
				ST_WALK: begin
					if (idx_q == IDXW'(CHANNELS - 1)) begin
						state_q <= ST_DONE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q     <= ST_EXEC;
						cal_q       <= 1'b0;
						status_q    <= STAT_OK;
						on_line_q   <= 1'b0;
						line_mask_q <= MASK_W'(mask_q);
						prev_mask_q <= MASK_W'(before_q);
						threshold_q <= thr_out;
					end
				end
				default: begin
					state_q <= ST_EXEC;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign on_line   = on_line_q;
	assign line_mask = line_mask_q;
	assign prev_mask = prev_mask_q;
	assign threshold = threshold_q;

endmodule
